@@ rtl/ptmd_pkg.sv @@
// package: table sizes, sequencer states and table write bundle
`timescale 1ns / 1ps
package ptmd_pkg;
	localparam int TABLE_ENTRIES = 64;
	localparam int SLOT_W = $clog2(TABLE_ENTRIES);
	localparam int PID_W = 16;
	localparam int LEVEL_W = 7;

	localparam logic [SLOT_W-1:0] COUNT_MAX_C = SLOT_W'(TABLE_ENTRIES - 1);
	localparam logic [SLOT_W:0]   ENTRIES_C   = (SLOT_W + 1)'(TABLE_ENTRIES);

	localparam logic FUNC_WRITE = 1'b0;
	localparam logic FUNC_QUERY = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ROOT,
		ST_CHECK,
		ST_LOAD,
		ST_SCAN,
		ST_LEVEL,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic              en;
		logic [SLOT_W-1:0] slot;
		logic              in_use;
		logic [SLOT_W-1:0] parent;
		logic [PID_W-1:0]  pid;
	} tbl_wr_t;
endpackage

@@ rtl/ptmd_if.sv @@
// request and response channel interfaces
`timescale 1ns / 1ps
interface ptmd_req_if;
	logic       valid;
	logic       ready;
	logic       func;
	logic [5:0] slot;
	logic       entry_in_use;
	logic [5:0] entry_parent;
	logic [15:0] entry_pid;
	logic signed [6:0] level_limit;
	logic [5:0] range_low;
	logic [5:0] range_high;

	modport source (output valid, func, slot, entry_in_use, entry_parent, entry_pid,
		level_limit, range_low, range_high, input ready);
	modport sink (input valid, func, slot, entry_in_use, entry_parent, entry_pid,
		level_limit, range_low, range_high, output ready);
endinterface

interface ptmd_rsp_if;
	logic        valid;
	logic        ready;
	logic [5:0]  best_count;
	logic [15:0] best_pid;
	logic        found;

	modport source (output valid, best_count, best_pid, found, input ready);
	modport sink (input valid, best_count, best_pid, found, output ready);
endinterface

@@ rtl/ptmd_table.sv @@
// process slot table: in-use flags, parent and id memories
`timescale 1ns / 1ps
module ptmd_table (
	input  logic                    clk,
	input  logic                    arst_n,
	input  ptmd_pkg::tbl_wr_t       wr,
	input  logic [ptmd_pkg::SLOT_W-1:0] scan_addr,
	input  logic [ptmd_pkg::SLOT_W-1:0] root_addr,
	output logic [ptmd_pkg::SLOT_W-1:0] parent_rd,
	output logic                    used_rd,
	output logic                    root_used,
	output logic [ptmd_pkg::PID_W-1:0]  pid_rd
);
	import ptmd_pkg::*;

	logic [TABLE_ENTRIES-1:0] used_q;
	logic [SLOT_W-1:0]        parent_mem [TABLE_ENTRIES];
	logic [PID_W-1:0]         pid_mem [TABLE_ENTRIES];
	logic [SLOT_W-1:0]        parent_rd_q;
	logic                     used_rd_q;
	logic [PID_W-1:0]         pid_rd_q;

	// in-use flags reset at once
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q <= '0;
		end else if (wr.en) begin
			used_q[wr.slot] <= wr.in_use;
		end
	end

	always_ff @(posedge clk) begin
		if (wr.en) begin
			parent_mem[wr.slot] <= wr.parent;
			pid_mem[wr.slot]    <= wr.pid;
		end
		parent_rd_q <= parent_mem[scan_addr];
		used_rd_q   <= used_q[scan_addr];
		pid_rd_q    <= pid_mem[root_addr];
	end

	assign parent_rd = parent_rd_q;
	assign used_rd   = used_rd_q;
	assign root_used = used_q[root_addr];
	assign pid_rd    = pid_rd_q;
endmodule

@@ rtl/process_tree_max_descendants_unit.sv @@
// top level: slot table writes and the breadth-first descendant query sequencer
`timescale 1ns / 1ps
// A write transaction (func 0) stores one slot and gives no response.
// A query transaction (func 1) walks every in-use slot as a root, breadth first, with
// one shared parent compare that scans the whole table once for each node that it
// expands; req.ready is low while the query runs. The response gives the largest
// descendant count inside [range_low, range_high], the id of the lowest slot reaching
// it, and found; a finished response waits in an output register while new
// transactions are accepted.
module process_tree_max_descendants_unit (
	input  logic      clk,
	input  logic      arst_n,
	ptmd_req_if.sink  req,
	ptmd_rsp_if.source rsp
);
	import ptmd_pkg::*;

	state_t state_q, state_d;

	// query setup
	logic                limit_all_q;
	logic [SLOT_W-1:0]   limit_q;
	logic [SLOT_W-1:0]   lo_q, hi_q;
	logic [SLOT_W-1:0]   best_q;
	logic [PID_W-1:0]    best_pid_q;

	// walk state
	logic [SLOT_W:0]     root_q;
	logic [SLOT_W:0]     elem_q;
	logic [SLOT_W:0]     level_q;
	logic [SLOT_W-1:0]   lvl_end_q;
	logic [SLOT_W-1:0]   count_q;
	logic [SLOT_W-1:0]   cur_q;
	logic [SLOT_W:0]     scan_j_q;
	logic                valid_s1;
	logic [SLOT_W-1:0]   j_s1;

	// response register
	logic                rsp_valid_q;
	logic [SLOT_W-1:0]   rsp_count_q;
	logic [PID_W-1:0]    rsp_pid_q;
	logic                rsp_found_q;

	// walk queue memory
	logic [SLOT_W-1:0]   queue_mem [TABLE_ENTRIES];
	logic [SLOT_W-1:0]   q_rd_q;
	logic                q_we;
	logic [SLOT_W-1:0]   q_waddr;
	logic [SLOT_W-1:0]   q_wdata;

	// table port
	tbl_wr_t             tbl_wr;
	logic [SLOT_W-1:0]   parent_rd;
	logic                used_rd;
	logic                root_used;
	logic [PID_W-1:0]    pid_rd;

	logic                accept;
	logic                hit;
	logic                walk_go;
	logic                in_range;
	logic                level_step;
	logic                rsp_free;
	logic [SLOT_W-1:0]   lo_sat, hi_sat;

	ptmd_table u_table (
		.clk       (clk),
		.arst_n    (arst_n),
		.wr        (tbl_wr),
		.scan_addr (scan_j_q[SLOT_W-1:0]),
		.root_addr (root_q[SLOT_W-1:0]),
		.parent_rd (parent_rd),
		.used_rd   (used_rd),
		.root_used (root_used),
		.pid_rd    (pid_rd)
	);

	assign accept   = req.valid && req.ready;
	assign rsp_free = !rsp_valid_q || rsp.ready;

	// range ends saturate to the largest possible count
	assign lo_sat = (req.range_low > COUNT_MAX_C) ? COUNT_MAX_C : req.range_low;
	assign hi_sat = (req.range_high > COUNT_MAX_C) ? COUNT_MAX_C : req.range_high;

	// a child found in the scan: used, not the node itself, parent matches, room left
	assign hit = valid_s1 && used_rd && (j_s1 != cur_q) && (parent_rd == cur_q) &&
		(count_q != COUNT_MAX_C);

	// loop condition of the breadth-first walk
	assign walk_go = (elem_q <= {1'b0, count_q}) && (elem_q < ENTRIES_C) &&
		(limit_all_q || (level_q != {1'b0, limit_q}));

	assign in_range = (count_q <= hi_q) && (count_q >= lo_q) && (count_q > best_q);

	// the node just scanned closes its level
	assign level_step = (level_q < ENTRIES_C) && (elem_q == {1'b0, lvl_end_q});

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept && (req.func == FUNC_QUERY)) state_d = ST_ROOT;
			end
			ST_ROOT: begin
				if (root_q == ENTRIES_C) state_d = ST_DONE;
				else if (root_used) state_d = ST_CHECK;
			end
			ST_CHECK: begin
				state_d = walk_go ? ST_LOAD : ST_ROOT;
			end
			ST_LOAD: begin
				state_d = ST_SCAN;
			end
			ST_SCAN: begin
				if ((scan_j_q == ENTRIES_C) && !valid_s1) state_d = ST_LEVEL;
			end
			ST_LEVEL: begin
				state_d = ST_CHECK;
			end
			ST_DONE: begin
				if (rsp_free) state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// control outputs
	always_comb begin
		req.ready    = 1'b0;
		q_we         = 1'b0;
		q_waddr      = count_q + SLOT_W'(1);
		q_wdata      = j_s1;
		case (state_q)
			ST_IDLE: begin
				req.ready = 1'b1;
			end
			ST_ROOT: begin
				// root goes to the head of the queue
				q_we    = (root_q != ENTRIES_C) && root_used;
				q_waddr = '0;
				q_wdata = root_q[SLOT_W-1:0];
			end
			ST_SCAN: begin
				q_we = hit;
			end
			default: begin
			end
		endcase
	end

	// table write straight from an accepted write transaction
	assign tbl_wr.en     = (state_q == ST_IDLE) && req.valid && (req.func == FUNC_WRITE) &&
		({1'b0, req.slot} < ENTRIES_C);
	assign tbl_wr.slot   = req.slot;
	assign tbl_wr.in_use = req.entry_in_use;
	assign tbl_wr.parent = req.entry_parent;
	assign tbl_wr.pid    = req.entry_pid;

	always_ff @(posedge clk) begin
		if (q_we) begin
			queue_mem[q_waddr] <= q_wdata;
		end
		q_rd_q <= queue_mem[elem_q[SLOT_W-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			root_q      <= '0;
			elem_q      <= '0;
			level_q     <= '0;
			lvl_end_q   <= '0;
			count_q     <= '0;
			scan_j_q    <= '0;
			valid_s1    <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			valid_s1 <= (state_q == ST_SCAN) && (scan_j_q != ENTRIES_C);
			if (rsp.ready) rsp_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (accept && (req.func == FUNC_QUERY)) root_q <= '0;
				end
				ST_ROOT: begin
					if (root_q != ENTRIES_C) begin
						if (root_used) begin
							count_q   <= '0;
							elem_q    <= '0;
							level_q   <= '0;
							lvl_end_q <= '0;
						end else begin
							root_q <= root_q + 1'b1;
						end
					end
				end
				ST_CHECK: begin
					if (!walk_go) root_q <= root_q + 1'b1;
				end
				ST_LOAD: begin
					scan_j_q <= '0;
				end
				ST_SCAN: begin
					if (scan_j_q != ENTRIES_C) scan_j_q <= scan_j_q + 1'b1;
					if (hit) count_q <= count_q + SLOT_W'(1);
				end
				ST_LEVEL: begin
					if (level_step) begin
						level_q <= level_q + 1'b1;
						if ((level_q + 1'b1) < ENTRIES_C) lvl_end_q <= count_q;
					end
					elem_q <= elem_q + 1'b1;
				end
				ST_DONE: begin
					if (rsp_free) rsp_valid_q <= 1'b1;
				end
				default: begin
				end
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		j_s1 <= scan_j_q[SLOT_W-1:0];
		case (state_q)
			ST_IDLE: begin
				if (accept && (req.func == FUNC_QUERY)) begin
					limit_all_q <= req.level_limit[LEVEL_W-1];
					limit_q     <= req.level_limit[SLOT_W-1:0];
					lo_q        <= lo_sat;
					hi_q        <= hi_sat;
					best_q      <= '0;
					best_pid_q  <= '0;
				end
			end
			ST_CHECK: begin
				// walk of this root finished: keep the first largest count in range
				if (!walk_go && in_range) begin
					best_q     <= count_q;
					best_pid_q <= pid_rd;
				end
			end
			ST_LOAD: begin
				cur_q <= q_rd_q;
			end
			ST_DONE: begin
				if (rsp_free) begin
					rsp_count_q <= best_q;
					rsp_pid_q   <= best_pid_q;
					rsp_found_q <= (best_q != '0);
				end
			end
			default: begin
			end
		endcase
	end

	assign rsp.valid      = rsp_valid_q;
	assign rsp.best_count = rsp_count_q;
	assign rsp.best_pid   = rsp_pid_q;
	assign rsp.found      = rsp_found_q;
endmodule

@@ rtl/ptmd_checker.sv @@
// port checker for the descendant query unit, bound to the top level
`timescale 1ns / 1ps
module ptmd_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        req_valid,
	input logic        req_ready,
	input logic        req_func,
	input logic        rsp_valid,
	input logic        rsp_ready,
	input logic [5:0]  rsp_best_count,
	input logic [15:0] rsp_best_pid,
	input logic        rsp_found
);
	import ptmd_pkg::*;

	// a stalled response keeps its payload
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_best_count) &&
		$stable(rsp_best_pid) && $stable(rsp_found))
		else $error("response changed while stalled");

	// found tracks a nonzero count
	a_found: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (rsp_found == (rsp_best_count != 6'd0)))
		else $error("found flag disagrees with count");

	// no id without a result
	a_pid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_found |-> (rsp_best_pid == 16'd0))
		else $error("id given without a result");

	// a query transaction holds off the request side next cycle
	a_query_busy: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready && (req_func == FUNC_QUERY) |=> !req_ready)
		else $error("ready while a query runs");
endmodule

bind process_tree_max_descendants_unit ptmd_checker u_ptmd_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.req_valid      (req.valid),
	.req_ready      (req.ready),
	.req_func       (req.func),
	.rsp_valid      (rsp.valid),
	.rsp_ready      (rsp.ready),
	.rsp_best_count (rsp.best_count),
	.rsp_best_pid   (rsp.best_pid),
	.rsp_found      (rsp.found)
);
